// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the detector's RTL files.
// Each macro clocks on clk and is disabled while rst_n is low; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication: whenever ante holds, cons holds too.
`define RSLD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define RSLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RSLD_ASSERT_IMPL(lbl, ante, cons, msg)
`define RSLD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/rsld_pkg.sv =====
// Shared types and constants for the regression slope leak detector.
// No dependencies; the front end, multiplier, back end and top level refer to it by scoped names.
package rsld_pkg;

  localparam int TIME_W  = 32;
  localparam int T_W     = 24;
  localparam int USAGE_W = 24;
  localparam int CNT_W   = 11;
  localparam int ST_W    = 34;
  localparam int STT_W   = 58;
  localparam int P_W     = 69;
  localparam int THR_W   = 24;

  // The shared multiplier works on 24-bit limbs: up to three limbs of the
  // first operand and two of the second, accumulated into 96 bits.
  localparam int LIMB_W  = 24;
  localparam int A_W     = 3 * LIMB_W;
  localparam int B_W     = 2 * LIMB_W;
  localparam int ACC_W   = 4 * LIMB_W;

  localparam logic [T_W-1:0] TIME_SAT    = {T_W{1'b1}};
  localparam int             SLOPE_SCALE = 15000;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int CMD_DEPTH_DEF   = 2;
  localparam int RES_DEPTH_DEF   = 2;

  typedef struct packed {
    logic               mode;
    logic [TIME_W-1:0]  time_ms;
    logic [USAGE_W-1:0] usage_kb;
  } in_item_t;

  typedef struct packed {
    logic             leak_detected;
    logic [CNT_W-1:0] sample_count;
    logic             sample_dropped;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_DROP   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [T_W-1:0]     t;
    logic [USAGE_W-1:0] usage;
    logic [CNT_W-1:0]   count;
  } cmd_t;

  typedef struct packed {
    logic [A_W-1:0] a;
    logic [B_W-1:0] b;
    logic [1:0]     a_last;
    logic           b_last;
  } mul_req_t;

endpackage

// ===== rtl/rsld_queue.sv =====
// Small register queue with full/empty flags, used for commands and for results.
// Depends on assert_macros.svh only.
`include "assert_macros.svh"

module rsld_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             wr_en, rd_en;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];
  assign wr_en = wr && !full;
  assign rd_en = rd && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (wr_en) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  // Producers check full themselves; a write into a full queue would lose an item.
  `RSLD_ASSERT_IMPL(a_no_overflow, wr, !full, "write into a full queue")

endmodule

// ===== rtl/rsld_front.sv =====
// Front end: accepts items, tracks start time and sample count, and classifies each
// item into a sample, clear or drop command. Depends on rsld_pkg.
module rsld_front #(
  parameter int MAX_SAMPLES = rsld_pkg::MAX_SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  rsld_pkg::in_item_t item,
  input  logic              cmd_full,
  output logic              cmd_wr,
  output rsld_pkg::cmd_t    cmd
);

  localparam int TW = rsld_pkg::TIME_W;
  localparam int CW = rsld_pkg::CNT_W;
  localparam int RW = rsld_pkg::T_W;

  logic [TW-1:0] start_r, start_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0] rel;
  logic [RW-1:0] t_sat;
  logic          accept;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;
  assign cmd_wr = accept;

  // Relative time, zero when the item is stamped before the start time and
  // saturated to 24 bits.
  assign rel = item.time_ms - start_r;

  always_comb begin
    if (item.time_ms < start_r) begin
      t_sat = '0;
    end else if (|rel[TW-1:RW]) begin
      t_sat = rsld_pkg::TIME_SAT;
    end else begin
      t_sat = rel[RW-1:0];
    end
  end

  always_comb begin
    start_nxt = start_r;
    cnt_nxt   = cnt_r;
    cmd.t     = t_sat;
    cmd.usage = item.usage_kb;
    if (item.mode) begin
      cmd.kind  = rsld_pkg::CMD_CLEAR;
      cmd.count = '0;
      if (accept) begin
        start_nxt = item.time_ms;
        cnt_nxt   = '0;
      end
    end else if (cnt_r >= CW'(MAX_SAMPLES)) begin
      cmd.kind  = rsld_pkg::CMD_DROP;
      cmd.count = cnt_r;
    end else begin
      cmd.kind  = rsld_pkg::CMD_SAMPLE;
      cmd.count = cnt_r + CW'(1);
      if (accept) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      cnt_r   <= '0;
    end else begin
      start_r <= start_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/rsld_mul.sv =====
// Shared limb-serial multiplier: one 24 x 24 partial product per cycle, registered,
// then shifted and accumulated into 96 bits. Depends on rsld_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rsld_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  rsld_pkg::mul_req_t          req,
  output logic                        done,
  output logic [rsld_pkg::ACC_W-1:0]  prod
);

  localparam int LW  = rsld_pkg::LIMB_W;
  localparam int AW  = rsld_pkg::A_W;
  localparam int BW  = rsld_pkg::B_W;
  localparam int ACW = rsld_pkg::ACC_W;

  logic            busy_r, busy_nxt;
  logic [1:0]      i_r, i_nxt;
  logic            j_r, j_nxt;
  logic [AW-1:0]   a_r, a_nxt;
  logic [BW-1:0]   b_r, b_nxt;
  logic [1:0]      a_last_r, a_last_nxt;
  logic            b_last_r, b_last_nxt;
  logic [2*LW-1:0] pp_r, pp_nxt;
  logic [1:0]      pos_r, pos_nxt;
  logic            pp_v_r, pp_v_nxt;
  logic            pp_last_r, pp_last_nxt;
  logic [ACW-1:0]  acc_r, acc_nxt;
  logic            done_r, done_nxt;
  logic [LW-1:0]   a_limb, b_limb;
  logic [ACW-1:0]  pp_shift;

  assign done = done_r;
  assign prod = acc_r;

  always_comb begin
    case (i_r)
      2'd0:    a_limb = a_r[LW-1:0];
      2'd1:    a_limb = a_r[2*LW-1:LW];
      2'd2:    a_limb = a_r[3*LW-1:2*LW];
      default: a_limb = '0;
    endcase
    b_limb = j_r ? b_r[2*LW-1:LW] : b_r[LW-1:0];
  end

  always_comb begin
    case (pos_r)
      2'd0:    pp_shift = {{(ACW-2*LW){1'b0}}, pp_r};
      2'd1:    pp_shift = {{(ACW-3*LW){1'b0}}, pp_r, {LW{1'b0}}};
      2'd2:    pp_shift = {pp_r, {(2*LW){1'b0}}};
      default: pp_shift = {pp_r[LW-1:0], {(3*LW){1'b0}}};
    endcase
  end

  always_comb begin
    busy_nxt    = busy_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    a_last_nxt  = a_last_r;
    b_last_nxt  = b_last_r;
    pp_nxt      = pp_r;
    pos_nxt     = pos_r;
    pp_v_nxt    = 1'b0;
    pp_last_nxt = 1'b0;
    acc_nxt     = acc_r;
    done_nxt    = pp_v_r && pp_last_r;

    if (start) begin
      busy_nxt   = 1'b1;
      i_nxt      = '0;
      j_nxt      = 1'b0;
      a_nxt      = req.a;
      b_nxt      = req.b;
      a_last_nxt = req.a_last;
      b_last_nxt = req.b_last;
      acc_nxt    = '0;
    end else begin
      if (busy_r) begin
        pp_nxt      = a_limb * b_limb;
        pos_nxt     = i_r + {1'b0, j_r};
        pp_v_nxt    = 1'b1;
        pp_last_nxt = (i_r == a_last_r) && (j_r == b_last_r);
        if (i_r == a_last_r) begin
          i_nxt = '0;
          if (j_r == b_last_r) begin
            busy_nxt = 1'b0;
          end else begin
            j_nxt = 1'b1;
          end
        end else begin
          i_nxt = i_r + 2'd1;
        end
      end
      if (pp_v_r) begin
        acc_nxt = acc_r + pp_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      pp_v_r    <= 1'b0;
      pp_last_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      pp_v_r    <= pp_v_nxt;
      pp_last_r <= pp_last_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    a_last_r <= a_last_nxt;
    b_last_r <= b_last_nxt;
    pp_r     <= pp_nxt;
    pos_r    <= pos_nxt;
    acc_r    <= acc_nxt;
  end

  // A new job must not overlap partial products still in flight.
  `RSLD_ASSERT_IMPL(a_no_overlap, start, !busy_r && !pp_v_r, "multiplier restarted while busy")
  // A job ends with one last partial product, so completion is a single-cycle pulse.
  `RSLD_ASSERT_NEXT(a_done_pulse, done_r, !done_r, "multiplier done held high")

endmodule

// ===== rtl/rsld_back.sv =====
// Back end: holds the running sums and the threshold, and sequences the shared
// multiplier through the slope test for each sample or drop command. Depends on rsld_pkg, assert_macros.svh.
`include "assert_macros.svh"

module rsld_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rsld_pkg::THR_W-1:0]   cfg_wdata,
  input  logic                         cmd_empty,
  output logic                         cmd_rd,
  input  rsld_pkg::cmd_t               cmd,
  input  logic                         res_full,
  output logic                         res_wr,
  output rsld_pkg::out_item_t          res,
  output logic                         mul_start,
  output rsld_pkg::mul_req_t           mul_req,
  input  logic                         mul_done,
  input  logic [rsld_pkg::ACC_W-1:0]   mul_prod
);

  localparam int AW   = rsld_pkg::A_W;
  localparam int BW   = rsld_pkg::B_W;
  localparam int CW   = rsld_pkg::CNT_W;
  localparam int STW  = rsld_pkg::ST_W;
  localparam int STTW = rsld_pkg::STT_W;
  localparam int PW   = rsld_pkg::P_W;
  localparam int TW   = rsld_pkg::T_W;
  localparam int UW   = rsld_pkg::USAGE_W;
  localparam int THW  = rsld_pkg::THR_W;
  localparam int ACW  = rsld_pkg::ACC_W;
  localparam int LW   = rsld_pkg::LIMB_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_DEN  = 6'b000100,
    ST_NUM  = 6'b001000,
    ST_CMP  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  // Multiplications in the order the sequencer issues them.
  typedef enum logic [2:0] {
    OP_TT = 3'd0,  // t * t
    OP_TU = 3'd1,  // t * usage
    OP_P  = 3'd2,  // n * sum(t*t)
    OP_Q  = 3'd3,  // sum(t) * sum(t)
    OP_A  = 3'd4,  // n * sum(t*u)
    OP_B  = 3'd5,  // sum(t) * sum(u)
    OP_L  = 3'd6,  // |num| * slope scale
    OP_R  = 3'd7   // denom * |threshold|
  } op_t;

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [STW-1:0]      st_r, st_nxt;
  logic [STW-1:0]      su_r, su_nxt;
  logic [STTW-1:0]     stt_r, stt_nxt;
  logic [STTW-1:0]     stu_r, stu_nxt;
  logic [THW-1:0]      thr_r, thr_nxt;
  logic [TW-1:0]       t_r, t_nxt;
  logic [UW-1:0]       u_r, u_nxt;
  logic [PW-1:0]       p_r, p_nxt;
  logic [PW-1:0]       pa_r, pa_nxt;
  logic [PW-1:0]       den_r, den_nxt;
  logic                den_pos_r, den_pos_nxt;
  logic                neg_num_r, neg_num_nxt;
  logic [ACW-1:0]      lhs_r, lhs_nxt;
  logic                drop_r, drop_nxt;
  rsld_pkg::out_item_t res_r, res_nxt;

  logic [PW:0]         diff_den, diff_ab, diff_ba;
  logic [THW-1:0]      thr_mag;
  logic                nn, nt, win;

  function automatic rsld_pkg::mul_req_t mk_req(input logic [AW-1:0] a,
                                                input logic [BW-1:0] b,
                                                input logic [1:0]    a_last,
                                                input logic          b_last);
    rsld_pkg::mul_req_t r;
    r.a      = a;
    r.b      = b;
    r.a_last = a_last;
    r.b_last = b_last;
    return r;
  endfunction

  assign res = res_r;

  // The multiplier holds its last product until the next start, so q and b
  // are read straight from its output.
  assign diff_den = {1'b0, p_r} - {1'b0, mul_prod[PW-1:0]};
  assign diff_ab  = {1'b0, pa_r} - {1'b0, mul_prod[PW-1:0]};
  assign diff_ba  = {1'b0, mul_prod[PW-1:0]} - {1'b0, pa_r};
  assign thr_mag  = thr_r[THW-1] ? (~thr_r + THW'(1)) : thr_r;

  // Sign-magnitude compare of num*15000 against threshold*denom; a zero
  // product counts as non-negative.
  always_comb begin
    nn = neg_num_r && (lhs_r != '0);
    nt = thr_r[THW-1] && (mul_prod != '0);
    if (nn != nt) begin
      win = !nn;
    end else if (!nn) begin
      win = lhs_r > mul_prod;
    end else begin
      win = lhs_r < mul_prod;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    n_nxt       = n_r;
    st_nxt      = st_r;
    su_nxt      = su_r;
    stt_nxt     = stt_r;
    stu_nxt     = stu_r;
    thr_nxt     = cfg_we ? cfg_wdata : thr_r;
    t_nxt       = t_r;
    u_nxt       = u_r;
    p_nxt       = p_r;
    pa_nxt      = pa_r;
    den_nxt     = den_r;
    den_pos_nxt = den_pos_r;
    neg_num_nxt = neg_num_r;
    lhs_nxt     = lhs_r;
    drop_nxt    = drop_r;
    res_nxt     = res_r;
    cmd_rd      = 1'b0;
    res_wr      = 1'b0;
    mul_start   = 1'b0;
    mul_req     = mk_req('0, '0, 2'd0, 1'b0);

    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_rd = 1'b1;
          case (cmd.kind)
            rsld_pkg::CMD_SAMPLE: begin
              t_nxt     = cmd.t;
              u_nxt     = cmd.usage;
              n_nxt     = n_r + CW'(1);
              st_nxt    = st_r + STW'(cmd.t);
              su_nxt    = su_r + STW'(cmd.usage);
              drop_nxt  = 1'b0;
              mul_start = 1'b1;
              mul_req   = mk_req(AW'(cmd.t), BW'(cmd.t), 2'd0, 1'b0);
              op_nxt    = OP_TT;
              state_nxt = ST_MUL;
            end
            rsld_pkg::CMD_DROP: begin
              drop_nxt  = 1'b1;
              mul_start = 1'b1;
              mul_req   = mk_req(AW'(stt_r), BW'(n_r), 2'd2, 1'b0);
              op_nxt    = OP_P;
              state_nxt = ST_MUL;
            end
            rsld_pkg::CMD_CLEAR: begin
              n_nxt     = '0;
              st_nxt    = '0;
              su_nxt    = '0;
              stt_nxt   = '0;
              stu_nxt   = '0;
              res_nxt   = '0;
              state_nxt = ST_OUT;
            end
            default: begin
            end
          endcase
        end
      end

      ST_MUL: begin
        if (mul_done) begin
          case (op_r)
            OP_TT: begin
              stt_nxt   = stt_r + STTW'(mul_prod[2*LW-1:0]);
              mul_start = 1'b1;
              mul_req   = mk_req(AW'(t_r), BW'(u_r), 2'd0, 1'b0);
              op_nxt    = OP_TU;
            end
            OP_TU: begin
              stu_nxt   = stu_r + STTW'(mul_prod[2*LW-1:0]);
              mul_start = 1'b1;
              mul_req   = mk_req(AW'(stt_r), BW'(n_r), 2'd2, 1'b0);
              op_nxt    = OP_P;
            end
            OP_P: begin
              p_nxt     = mul_prod[PW-1:0];
              mul_start = 1'b1;
              mul_req   = mk_req(AW'(st_r), BW'(st_r), 2'd1, 1'b1);
              op_nxt    = OP_Q;
            end
            OP_Q: begin
              state_nxt = ST_DEN;
            end
            OP_A: begin
              pa_nxt    = mul_prod[PW-1:0];
              mul_start = 1'b1;
              mul_req   = mk_req(AW'(st_r), BW'(su_r), 2'd1, 1'b1);
              op_nxt    = OP_B;
            end
            OP_B: begin
              state_nxt = ST_NUM;
            end
            OP_L: begin
              lhs_nxt   = mul_prod;
              mul_start = 1'b1;
              mul_req   = mk_req(AW'(den_r), BW'(thr_mag), 2'd2, 1'b0);
              op_nxt    = OP_R;
            end
            OP_R: begin
              state_nxt = ST_CMP;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_DEN: begin
        // denom = n*Stt - St*St; it must be strictly positive for a fit.
        den_nxt     = diff_den[PW-1:0];
        den_pos_nxt = !diff_den[PW] && (diff_den[PW-1:0] != '0);
        mul_start   = 1'b1;
        mul_req     = mk_req(AW'(stu_r), BW'(n_r), 2'd2, 1'b0);
        op_nxt      = OP_A;
        state_nxt   = ST_MUL;
      end

      ST_NUM: begin
        neg_num_nxt = diff_ab[PW];
        mul_start   = 1'b1;
        mul_req     = mk_req(AW'(diff_ab[PW] ? diff_ba[PW-1:0] : diff_ab[PW-1:0]),
                             BW'(rsld_pkg::SLOPE_SCALE), 2'd2, 1'b0);
        op_nxt      = OP_L;
        state_nxt   = ST_MUL;
      end

      ST_CMP: begin
        res_nxt.leak_detected  = win && den_pos_r && (n_r >= CW'(2));
        res_nxt.sample_count   = n_r;
        res_nxt.sample_dropped = drop_r;
        state_nxt              = ST_OUT;
      end

      ST_OUT: begin
        if (!res_full) begin
          res_wr    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      n_r     <= '0;
      st_r    <= '0;
      su_r    <= '0;
      stt_r   <= '0;
      stu_r   <= '0;
      thr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      st_r    <= st_nxt;
      su_r    <= su_nxt;
      stt_r   <= stt_nxt;
      stu_r   <= stu_nxt;
      thr_r   <= thr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    t_r       <= t_nxt;
    u_r       <= u_nxt;
    p_r       <= p_nxt;
    pa_r      <= pa_nxt;
    den_r     <= den_nxt;
    den_pos_r <= den_pos_nxt;
    neg_num_r <= neg_num_nxt;
    lhs_r     <= lhs_nxt;
    drop_r    <= drop_nxt;
    res_r     <= res_nxt;
  end

  // The front end's sample count and the back end's must never drift apart.
  `RSLD_ASSERT_IMPL(a_count_sync, cmd_rd && (cmd.kind == rsld_pkg::CMD_SAMPLE),
                    cmd.count == n_r + CW'(1), "front and back sample counts differ")
  // No line can be fitted through fewer than two samples.
  `RSLD_ASSERT_IMPL(a_leak_needs_two, res_wr && res_r.leak_detected, n_r >= CW'(2),
                    "leak reported with fewer than two samples")

endmodule

// ===== rtl/regression_slope_leak_detector.sv =====
// Top level of the regression slope leak detector: front end, command queue, back end,
// shared multiplier and result queue. Depends on rsld_pkg and the rsld_* modules.
// The back end handles one command at a time on its single shared 24 x 24 limb multiplier;
// the command queue lets the front end accept further items while the back end is busy.
// Reset (rst_n low, synchronous) empties both queues and zeroes sums, start time, threshold.
module regression_slope_leak_detector #(
  parameter int MAX_SAMPLES = rsld_pkg::MAX_SAMPLES_DEF,
  parameter int CMD_DEPTH   = rsld_pkg::CMD_DEPTH_DEF,
  parameter int RES_DEPTH   = rsld_pkg::RES_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  rsld_pkg::in_item_t         in_item,
  output logic                       empty,
  input  logic                       pop,
  output rsld_pkg::out_item_t        out_item,
  input  logic                       cfg_we,
  input  logic [rsld_pkg::THR_W-1:0] cfg_wdata
);

  // The front end classifies every accepted item on the spot. It keeps the
  // start time and its own copy of the sample count, so it can decide whether
  // a sample is kept or dropped and compute its saturated relative time
  // without waiting on the arithmetic behind it.
  logic                cmd_wr, cmd_full, cmd_empty, cmd_rd;
  rsld_pkg::cmd_t      cmd_in, cmd_out;

  // The back end walks a kept sample through the slope test: two products
  // that update the sums, then n*Stt, St*St, n*Stu, St*Su, |num|*15000 and
  // denom*|threshold|, all on one shared multiplier, and a final
  // sign-magnitude compare.
  logic                res_wr, res_full;
  rsld_pkg::out_item_t res_in;

  logic                mul_start, mul_done;
  rsld_pkg::mul_req_t  mul_req;
  logic [rsld_pkg::ACC_W-1:0] mul_prod;

  rsld_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .item     (in_item),
    .cmd_full (cmd_full),
    .cmd_wr   (cmd_wr),
    .cmd      (cmd_in)
  );

  // The command queue lets the front end keep taking items while the back
  // end is still busy with an earlier one.
  rsld_queue #(
    .WIDTH ($bits(rsld_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (cmd_wr),
    .wdata (cmd_in),
    .rd    (cmd_rd),
    .rdata (cmd_out),
    .full  (cmd_full),
    .empty (cmd_empty)
  );

  rsld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_empty (cmd_empty),
    .cmd_rd    (cmd_rd),
    .cmd       (cmd_out),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res       (res_in),
    .mul_start (mul_start),
    .mul_req   (mul_req),
    .mul_done  (mul_done),
    .mul_prod  (mul_prod)
  );

  rsld_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Finished results wait here, so a stalled consumer only stops the back
  // end once this queue is full.
  rsld_queue #(
    .WIDTH ($bits(rsld_pkg::out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (res_wr),
    .wdata (res_in),
    .rd    (pop),
    .rdata (out_item),
    .full  (res_full),
    .empty (empty)
  );

endmodule

// ===== test/tb_regression_slope_leak_detector.sv =====
// Self-checking testbench for regression_slope_leak_detector: random and directed sample
// streams, a cycle-free least-squares leak predictor and a result scoreboard.
// Depends only on rsld_pkg and the detector RTL.
`timescale 1ns / 100ps

module tb_regression_slope_leak_detector;

  localparam int THR_W   = rsld_pkg::THR_W;
  localparam int TIME_W  = rsld_pkg::TIME_W;
  localparam int T_W     = rsld_pkg::T_W;
  localparam int USAGE_W = rsld_pkg::USAGE_W;
  localparam int CNT_W   = rsld_pkg::CNT_W;
  localparam int ST_W    = rsld_pkg::ST_W;
  localparam int STT_W   = rsld_pkg::STT_W;

  localparam int MAX_HELD = rsld_pkg::MAX_SAMPLES_DEF;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 90;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 64;

  // Values of the mode field of an input item.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  // Scale from kB/ms to MB/min with eight fraction bits folded in (60000 / 1024 * 256).
  localparam logic signed [127:0] RATE_SCALE = rsld_pkg::SLOPE_SCALE;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  rsld_pkg::in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  rsld_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [THR_W-1:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  regression_slope_leak_detector #(
    .MAX_SAMPLES(MAX_HELD)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Items waiting to be offered to the block, and the verdicts it owes us, oldest first.
  rsld_pkg::in_item_t  pending[$];
  rsld_pkg::out_item_t verdicts_due[$];

  // Predictor copy of the detector's state. The block is reset once, so these start at zero.
  logic [THR_W-1:0]  thr_q8   = '0;
  logic [TIME_W-1:0] t0_ms    = '0;
  logic [CNT_W-1:0]  n_held   = '0;
  logic [ST_W-1:0]   sum_t    = '0;
  logic [ST_W-1:0]   sum_u    = '0;
  logic [STT_W-1:0]  sum_tt   = '0;
  logic [STT_W-1:0]  sum_tu   = '0;

  // When set, neither side idles; the last phase runs at full rate.
  bit calm = 1'b0;

  int items_queued = 0;
  int items_taken = 0;
  int results_checked = 0;
  int leaks_seen = 0;
  int drops_seen = 0;
  int mismatches = 0;
  int gap_left = 0;
  bit gap_done = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  // The least-squares leak test on the current sums. The slope is num / denom in kB/ms,
  // with num = n*Stu - St*Su and denom = n*Stt - St*St. Rather than divide, the test
  // num * 15000 > threshold * denom is evaluated exactly in 128-bit signed arithmetic,
  // which is wide enough for every product the sums allow.
  function automatic logic slope_exceeds();
    logic [127:0] p, q, a, b;
    logic signed [127:0] num, denom, thr, lhs, rhs;
    if (n_held < 2) return 1'b0;
    p = 128'(n_held) * 128'(sum_tt);
    q = 128'(sum_t) * 128'(sum_t);
    // All relative times equal (or a lone point) gives no line to fit.
    if (p <= q) return 1'b0;
    a = 128'(n_held) * 128'(sum_tu);
    b = 128'(sum_t) * 128'(sum_u);
    num = a - b;
    denom = p - q;
    thr = {{(128 - THR_W){thr_q8[THR_W-1]}}, thr_q8};
    lhs = num * RATE_SCALE;
    rhs = thr * denom;
    return lhs > rhs;
  endfunction

  // Applies one accepted item to the predictor state and queues the verdict it must produce.
  task automatic predict_verdict(input rsld_pkg::in_item_t it);
    logic [TIME_W-1:0] rel;
    logic [T_W-1:0] t;
    rsld_pkg::out_item_t v;
    v = '0;
    if (it.mode == MODE_CLEAR) begin
      // A clear drops every sum and restarts the time base at this item's time.
      n_held = '0;
      sum_t = '0;
      sum_u = '0;
      sum_tt = '0;
      sum_tu = '0;
      t0_ms = it.time_ms;
    end else if (n_held >= MAX_HELD) begin
      // At capacity the sample is ignored, but the current leak test is still reported.
      v.sample_dropped = 1'b1;
    end else begin
      // Time before the start counts as zero; long spans saturate at the 24-bit limit.
      rel = (it.time_ms >= t0_ms) ? it.time_ms - t0_ms : '0;
      t = (rel > TIME_W'(rsld_pkg::TIME_SAT)) ? rsld_pkg::TIME_SAT : rel[T_W-1:0];
      n_held = n_held + 1'b1;
      sum_t = sum_t + ST_W'(t);
      sum_u = sum_u + ST_W'(it.usage_kb);
      sum_tt = sum_tt + STT_W'(t) * STT_W'(t);
      sum_tu = sum_tu + STT_W'(t) * STT_W'(it.usage_kb);
    end
    v.leak_detected = slope_exceeds();
    v.sample_count = n_held;
    verdicts_due = {verdicts_due, v};
  endtask

  task automatic queue_item(input logic mode, input logic [TIME_W-1:0] when,
                            input logic [USAGE_W-1:0] usage);
    rsld_pkg::in_item_t it;
    it.mode = mode;
    it.time_ms = when;
    it.usage_kb = usage;
    pending = {pending, it};
    items_queued++;
  endtask

  // One measurement run: a clear, then samples that follow a random linear trend with
  // jitter. Unless the run is clean, some items break the pattern on purpose: a stray
  // clear, time that steps back, repeated timestamps, huge jumps and wild usage values.
  task automatic queue_trend(input int n_samples, input bit clean);
    logic [TIME_W-1:0] now;
    int level, rate, r, dt;
    now = $urandom;
    queue_item(MODE_CLEAR, now, USAGE_W'($urandom));
    level = $urandom_range(0, (1 << USAGE_W) - 1);
    rate = int'($urandom_range(0, 60)) - 30;
    for (int i = 0; i < n_samples; i++) begin
      r = clean ? 99 : $urandom_range(0, 99);
      if (r < 3) begin
        now = now + $urandom_range(0, 500);
        queue_item(MODE_CLEAR, now, USAGE_W'($urandom));
      end else begin
        if (r < 6) dt = -int'($urandom_range(1, 5000));
        else if (r < 9) dt = 0;
        else if (r < 12) dt = $urandom_range(1 << 20, 1 << 25);
        else dt = $urandom_range(1, 3000);
        now = now + TIME_W'(dt);
        // The trend is in kB per 100 ms, so the fitted slope lands near the thresholds
        // used in the middle phases.
        level = level + rate * dt / 100 + int'($urandom_range(0, 400)) - 200;
        if (level < 0) level = 0;
        if (level > (1 << USAGE_W) - 1) level = (1 << USAGE_W) - 1;
        queue_item(MODE_SAMPLE, now,
                   (r >= 12 && r < 15) ? USAGE_W'($urandom) : USAGE_W'(level));
      end
    end
  endtask

  // Short hand-picked opening under the reset threshold of zero.
  task automatic queue_directed();
    // A lone sample, then a second one at the same time: too few points, then flat time.
    queue_item(MODE_SAMPLE, 32'd0, 24'd0);
    queue_item(MODE_SAMPLE, 32'd0, 24'hFFFFFF);
    // Time at its maximum saturates the relative time.
    queue_item(MODE_SAMPLE, 32'hFFFF_FFFF, 24'hFFFFFF);
    queue_item(MODE_SAMPLE, 32'd5000, 24'd100);
    // A clear at the top of the time range; its usage is ignored.
    queue_item(MODE_CLEAR, 32'hFFFF_FFFF, 24'hFFFFFF);
    // Both samples fall before the new start, so their relative time is zero.
    queue_item(MODE_SAMPLE, 32'd1000, 24'd7);
    queue_item(MODE_SAMPLE, 32'd0, 24'd9);
    // A rising run, then a falling one.
    queue_item(MODE_CLEAR, 32'd1000, 24'd0);
    for (int i = 1; i <= 6; i++) queue_item(MODE_SAMPLE, 32'd1000 + 100 * i, 24'(500 * i));
    for (int i = 1; i <= 4; i++) queue_item(MODE_SAMPLE, 32'd1600 + 100 * i, 24'(3000 - 700 * i));
    // Spans just past and exactly at the saturation limit, then a tiny one.
    queue_item(MODE_CLEAR, 32'h8000_0000, 24'h555555);
    queue_item(MODE_SAMPLE, 32'h8100_0000, 24'hAAAAAA);
    queue_item(MODE_SAMPLE, 32'h80FF_FFFF, 24'h555555);
    queue_item(MODE_SAMPLE, 32'h8000_0001, 24'd1);
  endtask

  // Waits on the falling edge until every queued item is taken and every verdict is in.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending.size() != 0 || push || verdicts_due.size() != 0);
  endtask

  // The threshold register is written only while the block holds no work.
  task automatic write_threshold(input logic [THR_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_q8 = val;
  endtask

  // Driver: offers pending items one at a time, holding push until the item is taken.
  // Before a new item it sometimes idles for a random burst of cycles.
  always @(posedge clk) begin : item_driver
    bit took;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      took = push && !full;
      if (took) begin
        predict_verdict(in_item);
        items_taken++;
      end
      if (!push || took) begin
        if (gap_left != 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending.size() != 0) begin
          if (!calm && !gap_done && $urandom_range(0, 2) == 0) begin
            gap_left = $urandom_range(1, 14) - 1;
            gap_done = 1'b1;
            push <= 1'b0;
          end else begin
            in_item <= pending.pop_front();
            push <= 1'b1;
            gap_done = 1'b0;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: pops results and checks each against the oldest outstanding verdict.
  // Pop drops for random bursts so that stalls land at every point of the block's work.
  always @(posedge clk) begin : result_monitor
    rsld_pkg::out_item_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_checked++;
        if (out_item.leak_detected) leaks_seen++;
        if (out_item.sample_dropped) drops_seen++;
        if (verdicts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing outstanding: leak=%0b count=%0d dropped=%0b",
                     $realtime, out_item.leak_detected, out_item.sample_count,
                     out_item.sample_dropped);
        end else begin
          want = verdicts_due.pop_front();
          if (out_item.leak_detected !== want.leak_detected ||
              out_item.sample_count !== want.sample_count ||
              out_item.sample_dropped !== want.sample_dropped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d: want leak=%0b count=%0d dropped=%0b, got %0b %0d %0b",
                       $realtime, results_checked, want.leak_detected, want.sample_count,
                       want.sample_dropped, out_item.leak_detected, out_item.sample_count,
                       out_item.sample_dropped);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d verdicts outstanding",
               WATCHDOG_LIMIT, verdicts_due.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sequencer: reset, the directed opening, then one phase per threshold setting.
  // Phase 0 and 1 use the most negative and most positive thresholds, phase 2 fills the
  // sample store past capacity, and the rest use thresholds near typical fitted slopes.
  initial begin : sequencer
    int target;
    logic [THR_W-1:0] thr;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    queue_directed();
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      if (ph == 0) thr = {1'b1, {(THR_W - 1){1'b0}}};
      else if (ph == 1) thr = {1'b0, {(THR_W - 1){1'b1}}};
      else thr = THR_W'(int'($urandom_range(0, 8000)) - 4000);
      write_threshold(thr);
      @(negedge clk);
      calm = (ph == N_PHASES - 1);
      if (ph == 2) begin
        // A clean run past capacity, so the last samples are dropped.
        queue_trend(MAX_HELD + 6, 1'b1);
      end else begin
        target = items_queued + PHASE_ITEMS;
        while (items_queued < target) queue_trend($urandom_range(3, 40), 1'b0);
      end
    end
    wait_drained();
    // Let any result the block should not produce show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      mismatches++;
      $display("%0d verdicts never arrived", verdicts_due.size());
    end
    $display("Ran %0d items over %0d threshold settings and checked %0d results.",
             items_taken, N_PHASES + 1, results_checked);
    $display("%0d results reported a leak and %0d samples were dropped at capacity.",
             leaks_seen, drops_seen);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rsld_pkg.sv
rtl/rsld_queue.sv
rtl/rsld_front.sv
rtl/rsld_mul.sv
rtl/rsld_back.sv
rtl/regression_slope_leak_detector.sv
test/tb_regression_slope_leak_detector.sv
